### rtl/opmm_pkg.sv
// Package for the outer-product matrix multiply block.
// Holds request codes, status codes, sizes and the command struct.
// No dependencies.
package opmm_pkg;

   localparam int ROWS_DEF  = 4;
   localparam int COLS_DEF  = 32;
   localparam int INNER_DEF = 8;

   localparam int TYPE_W = 3;
   localparam int IDX_W  = 5;
   localparam int VAL_W  = 16;
   localparam int ACC_W  = 40;
   localparam int STAT_W = 2;

   localparam logic [TYPE_W-1:0] REQ_WR_A    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_WR_B    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_WR_C    = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_COMPUTE = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_RD_C    = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_IDX = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SAT = 2'd2;

   // Operation classes decided by the front end
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_WR_A = 3'd1;
   localparam logic [2:0] OP_WR_B = 3'd2;
   localparam logic [2:0] OP_WR_C = 3'd3;
   localparam logic [2:0] OP_COMP = 3'd4;
   localparam logic [2:0] OP_RD_C = 3'd5;

   typedef struct packed {
      logic [2:0]        op;
      logic              bad_idx;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [VAL_W-1:0]  value;
   } cmd_type;

endpackage

### rtl/opmm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module opmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/opmm_front.sv
// Front end: accepts request items, range-checks and classifies them.
// Depends on opmm_pkg.
module opmm_front #(
   parameter int ROWS  = opmm_pkg::ROWS_DEF,
   parameter int COLS  = opmm_pkg::COLS_DEF,
   parameter int INNER = opmm_pkg::INNER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [opmm_pkg::TYPE_W-1:0]   req_type,
   input  logic [opmm_pkg::IDX_W-1:0]    req_row_index,
   input  logic [opmm_pkg::IDX_W-1:0]    req_col_index,
   input  logic signed [opmm_pkg::VAL_W-1:0] req_element_value,
   output logic                          cmd_valid,
   input  logic                          cmd_stall,
   output opmm_pkg::cmd_type             cmd
);
   import opmm_pkg::*;

   localparam int QD = 2;
   cmd_type          q_ff [QD];
   logic [1:0]       cnt_ff, cnt_in;
   logic             wr_ptr_ff, rd_ptr_ff;
   cmd_type          cls;
   logic             push, pop;

   // Classify the incoming item
   always_comb begin
      cls.row   = req_row_index;
      cls.col   = req_col_index;
      cls.value = req_element_value;
      cls.bad_idx = 1'b0;
      case (req_type)
         REQ_WR_A: begin
            cls.op = OP_WR_A;
            cls.bad_idx = ({1'b0, req_row_index} >= 6'(ROWS)) ||
                          ({1'b0, req_col_index} >= 6'(INNER));
         end
         REQ_WR_B: begin
            cls.op = OP_WR_B;
            cls.bad_idx = ({1'b0, req_row_index} >= 6'(INNER)) ||
                          ({1'b0, req_col_index} >= 6'(COLS));
         end
         REQ_WR_C: begin
            cls.op = OP_WR_C;
            cls.bad_idx = ({1'b0, req_row_index} >= 6'(ROWS)) ||
                          ({1'b0, req_col_index} >= 6'(COLS));
         end
         REQ_COMPUTE: cls.op = OP_COMP;
         REQ_RD_C: begin
            cls.op = OP_RD_C;
            cls.bad_idx = ({1'b0, req_row_index} >= 6'(ROWS)) ||
                          ({1'b0, req_col_index} >= 6'(COLS));
         end
         default: cls.op = OP_NONE;
      endcase
   end

   // Two-entry queue toward the back end
   assign req_stall = (cnt_ff == 2'(QD));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && !cmd_stall;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
      if (push) q_ff[wr_ptr_ff] <= cls;
   end
endmodule

### rtl/opmm_back.sv
// Back end: executes commands against the A, B, C memories and the MAC.
// Depends on opmm_pkg and opmm_ram.
module opmm_back #(
   parameter int ROWS  = opmm_pkg::ROWS_DEF,
   parameter int COLS  = opmm_pkg::COLS_DEF,
   parameter int INNER = opmm_pkg::INNER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_stall,
   input  opmm_pkg::cmd_type                  cmd,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [opmm_pkg::ACC_W-1:0]  rsp_read_value,
   output logic [opmm_pkg::STAT_W-1:0]        rsp_status
);
   import opmm_pkg::*;

   localparam int AD = ROWS * INNER;
   localparam int BD = INNER * COLS;
   localparam int CD = ROWS * COLS;
   localparam int AAW = (AD > 1) ? $clog2(AD) : 1;
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
   localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
   localparam int KW = (INNER > 1) ? $clog2(INNER) : 1;
   localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int JW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_COMP  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [CAW-1:0] clr_ff;
   logic [KW-1:0] k_ff;
   logic [IW-1:0] i_ff;
   logic [JW-1:0] j_ff;
   logic          issue_ff;
   // MAC pipeline: s1 = rams read, s2 = product registered, sum written
   logic          v1_ff, v2_ff, last1_ff, last2_ff;
   logic [CAW-1:0] ca1_ff, ca2_ff;
   logic signed [2*VAL_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]   cold_ff;
   logic          sat_ff;
   logic signed [ACC_W-1:0] rval_ff;
   logic [STAT_W-1:0]       stat_ff;
   logic                    rvalid_ff;
   logic                    rd_pend_ff;

   // RAM ports
   logic            a_we, b_we, c_we;
   logic [AAW-1:0]  a_wa, a_ra;
   logic [BAW-1:0]  b_wa, b_ra;
   logic [CAW-1:0]  c_wa, c_ra;
   logic [VAL_W-1:0] a_rd, b_rd;
   logic [ACC_W-1:0] c_wd, c_rd;

   opmm_ram #(.WIDTH(VAL_W), .DEPTH(AD)) u_a (
      .clock, .wr_en(a_we), .wr_addr(a_wa), .wr_data(cmd.value),
      .rd_addr(a_ra), .rd_data(a_rd));
   opmm_ram #(.WIDTH(VAL_W), .DEPTH(BD)) u_b (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(cmd.value),
      .rd_addr(b_ra), .rd_data(b_rd));
   opmm_ram #(.WIDTH(ACC_W), .DEPTH(CD)) u_c (
      .clock, .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
      .rd_addr(c_ra), .rd_data(c_rd));

   logic take;
   logic [2*IDX_W-1:0] a_lin, b_lin, c_lin;
   assign a_lin = 10'(cmd.row) * 10'(INNER) + 10'(cmd.col);
   assign b_lin = 10'(cmd.row) * 10'(COLS) + 10'(cmd.col);
   assign c_lin = 10'(cmd.row) * 10'(COLS) + 10'(cmd.col);

   assign cmd_stall = !(state_ff == ST_IDLE) || rvalid_ff;
   assign take = cmd_valid && !cmd_stall;

   // Saturating add of the registered product into the old C value
   logic signed [ACC_W:0] sum;
   logic signed [ACC_W-1:0] sum_sat;
   logic                    sum_ovf;
   always_comb begin
      sum = {cold_ff[ACC_W-1], cold_ff} + (ACC_W+1)'(prod_ff);
      sum_ovf = (sum[ACC_W] != sum[ACC_W-1]);
      if (!sum_ovf)        sum_sat = sum[ACC_W-1:0];
      else if (sum[ACC_W]) sum_sat = ACC_MIN;
      else                 sum_sat = ACC_MAX;
   end

   logic [CAW-1:0] iss_ca;
   assign iss_ca = CAW'(i_ff) * CAW'(COLS) + CAW'(j_ff);

   // Memory port control
   always_comb begin
      a_we = take && cmd.op == OP_WR_A && !cmd.bad_idx;
      b_we = take && cmd.op == OP_WR_B && !cmd.bad_idx;
      a_wa = AAW'(a_lin);
      b_wa = BAW'(b_lin);
      a_ra = AAW'(32'(i_ff) * INNER + 32'(k_ff));
      b_ra = BAW'(32'(k_ff) * COLS + 32'(j_ff));
      c_ra = (state_ff == ST_COMP) ? iss_ca : CAW'(c_lin);
      c_we = 1'b0;
      c_wa = CAW'(c_lin);
      c_wd = {{(ACC_W-VAL_W-16){cmd.value[VAL_W-1]}}, cmd.value, 16'd0};
      if (state_ff == ST_CLEAR) begin
         c_we = 1'b1; c_wa = clr_ff; c_wd = '0;
      end else if (v2_ff) begin
         c_we = 1'b1; c_wa = ca2_ff; c_wd = sum_sat;
      end else if (take && cmd.op == OP_WR_C && !cmd.bad_idx) begin
         c_we = 1'b1;
      end
   end

   // Sequencer
   logic last_iss;
   assign last_iss = (k_ff == KW'(INNER-1)) && (i_ff == IW'(ROWS-1)) &&
                     (j_ff == JW'(COLS-1));
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == CAW'(CD-1)) state_in = ST_IDLE;
         ST_IDLE:  if (take && cmd.op == OP_COMP) state_in = ST_COMP;
         ST_COMP:  if (issue_ff && last_iss) state_in = ST_RESP;
         ST_RESP:  if (v2_ff && last2_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // A read-after-write hazard on C exists when the same element is reissued
   // within the pipeline; the ph_ff counter spaces issues to keep ordering simple.
   logic [1:0] ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         k_ff <= '0; i_ff <= '0; j_ff <= '0;
         ph_ff <= '0;
         issue_ff <= 1'b0;
         v1_ff <= 1'b0; v2_ff <= 1'b0;
         sat_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + CAW'(1);
         v1_ff <= issue_ff;
         last1_ff <= issue_ff && last_iss;
         ca1_ff <= iss_ca;
         v2_ff <= v1_ff;
         last2_ff <= last1_ff;
         ca2_ff <= ca1_ff;
         issue_ff <= 1'b0;
         if (state_ff == ST_COMP) begin
            ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
            issue_ff <= (ph_ff == 2'd0);
            if (issue_ff) begin
               if (j_ff == JW'(COLS-1)) begin
                  j_ff <= '0;
                  if (i_ff == IW'(ROWS-1)) begin
                     i_ff <= '0;
                     k_ff <= (k_ff == KW'(INNER-1)) ? '0 : k_ff + KW'(1);
                  end else i_ff <= i_ff + IW'(1);
               end else j_ff <= j_ff + JW'(1);
            end
         end else ph_ff <= '0;
         if (take && cmd.op == OP_COMP) sat_ff <= 1'b0;
         if (v2_ff && sum_ovf) sat_ff <= 1'b1;
         rd_pend_ff <= 1'b0;
         if (rsp_valid && !rsp_stall) rvalid_ff <= 1'b0;
         if (take && cmd.op != OP_COMP) begin
            if (cmd.op == OP_RD_C && !cmd.bad_idx) rd_pend_ff <= 1'b1;
            rvalid_ff <= 1'b1;
         end
         if (v2_ff && last2_ff) rvalid_ff <= 1'b1;
      end
      // Pipeline payload
      prod_ff <= $signed(a_rd) * $signed(b_rd);
      cold_ff <= c_rd;
      if (take) begin
         rval_ff <= '0;
         stat_ff <= cmd.bad_idx ? STAT_IDX : STAT_OK;
      end
      if (rd_pend_ff) rval_ff <= c_rd;
      if (v2_ff && last2_ff)
         stat_ff <= (sat_ff || sum_ovf) ? STAT_SAT : STAT_OK;
   end

   assign rsp_valid      = rvalid_ff && !rd_pend_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_status     = stat_ff;
endmodule

### rtl/outer_product_matrix_multiply.sv
// Top level of the outer-product matrix multiply block.
// Depends on opmm_pkg, opmm_front, opmm_back, opmm_ram.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  type, row, col, element value
//   rsp      out        rsp_valid/rsp_stall  read value, status
//
// Load, preset and read items answer through the single response register;
// a read also waits for the registered C memory read. No new item is taken
// while a response is pending. A compute item issues one MAC for each row,
// column and inner index, spaced out to keep the C read-modify-write in order.
// After reset the C memory is cleared entry by entry; no item enters.
// A two-entry queue lets requests land while a response is stalled.
module outer_product_matrix_multiply #(
   parameter int ROWS  = opmm_pkg::ROWS_DEF,
   parameter int COLS  = opmm_pkg::COLS_DEF,
   parameter int INNER = opmm_pkg::INNER_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [opmm_pkg::TYPE_W-1:0]         req_type,
   input  logic [opmm_pkg::IDX_W-1:0]          req_row_index,
   input  logic [opmm_pkg::IDX_W-1:0]          req_col_index,
   input  logic signed [opmm_pkg::VAL_W-1:0]   req_element_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [opmm_pkg::ACC_W-1:0]   rsp_read_value,
   output logic [opmm_pkg::STAT_W-1:0]         rsp_status
);
   import opmm_pkg::*;

   logic    cmd_valid, cmd_stall;
   cmd_type cmd;

   opmm_front #(.ROWS(ROWS), .COLS(COLS), .INNER(INNER)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_row_index,
      .req_col_index, .req_element_value, .cmd_valid, .cmd_stall, .cmd);

   opmm_back #(.ROWS(ROWS), .COLS(COLS), .INNER(INNER)) u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd, .rsp_valid, .rsp_stall,
      .rsp_read_value, .rsp_status);
endmodule
